// File: src/pfr_pkg.sv
// package for the page framebuffer refresh block: codes, defaults, byte spreading
// used by pfr_ram users and page_framebuffer_refresh; depends on nothing
`default_nettype none

package pfr_pkg;

    // default display geometry
    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 64;

    // slots before the column bytes of each page
    localparam int HEADER_SLOTS = 4;

    // header slot codes within a page
    localparam logic [1:0] SLOT_COL_CMD  = 2'd0;
    localparam logic [1:0] SLOT_COL_ZERO = 2'd1;
    localparam logic [1:0] SLOT_PAGE_CMD = 2'd2;
    localparam logic [1:0] SLOT_PAGE_NUM = 2'd3;

    // command marker on odd word bits
    localparam logic [15:0] CMD_MARK = 16'hAAAA;

    // item kinds
    localparam logic [1:0] OP_DRAW    = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;

    // pixel modes (anything above invert turns the pixel on)
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_INVERT = 2'd1;

    // register indexes
    localparam logic [7:0] REG_COL_CMD  = 8'd0;
    localparam logic [7:0] REG_PAGE_CMD = 8'd1;

    // bit b of the byte lands on word bit 2b, commands also set the odd bits
    function automatic logic [15:0] spread_byte(input logic [7:0] byte_in,
                                                input logic is_cmd);
        logic [15:0] word;
        word = 16'd0;
        for (int b = 0; b < 8; b++) begin
            word[2*b] = byte_in[b];
        end
        if (is_cmd) begin
            word = word | CMD_MARK;
        end
        return word;
    endfunction

endpackage

`default_nettype wire

// File: src/pfr_ram.sv
// generic single-port ram with registered read data (read before write)
// depends on nothing
`default_nettype none

module pfr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // one access per cycle, old contents come out on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/page_framebuffer_refresh.sv
// top level of the monochrome page framebuffer with refresh word generator
// depends on pfr_pkg and pfr_ram
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  s       | in        | i_s_tvalid/o_s_tready  | tuser op, tdata x, y, mode
//  m       | out       | o_m_tvalid/i_m_tready  | tdata link word, tlast frame end
//  cfg     | in        | i_cfg_valid/o_cfg_ready| register index, 8-bit value
//
// every on-screen draw or refresh item reads the single-port store while idle, then either
// writes the modified byte back (S_RMW) or loads the output register (S_REFRESH).
// off-screen draws and unused op codes leave the block idle.
// a clear item sweeps the store, zeroing all 2**(page bits + column bits) addresses (1024 by default).
// after reset the same sweep runs before the first item is taken.
// a refresh item is taken only when the output register is free or being emptied;
// draw and clear items are taken while a word waits at the output.
`default_nettype none

module page_framebuffer_refresh
    import pfr_pkg::*;
#(
    parameter int WIDTH  = DEF_WIDTH,
    parameter int HEIGHT = DEF_HEIGHT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // [15:0] pixel_x, [31:16] pixel_y,
                                          // [33:32] pixel_mode, [39:34] zero
    input  wire logic [1:0]  i_s_tuser,   // [1:0] op
    // result items
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata,   // [15:0] link_word
    output logic             o_m_tlast,   // frame_last
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int PAGES = HEIGHT / 8;
    localparam int ROWS  = PAGES * 8;
    localparam int CW    = $clog2(WIDTH);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = PW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int SLOTS = WIDTH + HEADER_SLOTS;
    localparam int SW    = $clog2(SLOTS);

    typedef enum logic [3:0] {
        S_CLEAR   = 4'b0001,
        S_IDLE    = 4'b0010,
        S_RMW     = 4'b0100,
        S_REFRESH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_addr;
    logic [7:0]    r_mask;
    logic [1:0]    r_mode;
    logic [PW-1:0] r_scan_page;
    logic [SW-1:0] r_scan_slot;
    logic          r_is_data;
    logic [1:0]    r_hdr_sel;
    logic [PW-1:0] r_hdr_page;
    logic          r_last_pend;
    logic          r_out_valid;
    logic [15:0]   r_out_word;
    logic          r_out_last;
    logic [7:0]    r_col_code;
    logic [7:0]    r_page_code;

    logic [15:0]   s_x;
    logic [15:0]   s_y;
    logic [1:0]    s_mode;
    logic          s_accept;
    logic          m_accept;
    logic          draw_ok;
    logic          slot_wrap;
    logic          page_wrap;
    logic [SW-1:0] col_slot;
    logic [AW-1:0] draw_addr;
    logic [AW-1:0] scan_addr;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [7:0]    mod_byte;
    logic [7:0]    word_byte;

    // field unpacking and handshakes
    assign s_x      = i_s_tdata[15:0];
    assign s_y      = i_s_tdata[31:16];
    assign s_mode   = i_s_tdata[33:32];
    assign o_s_tready = (r_state == S_IDLE) &&
                        ((i_s_tuser != OP_REFRESH) || !r_out_valid || i_m_tready);
    assign s_accept = i_s_tvalid && o_s_tready;
    assign m_accept = r_out_valid && i_m_tready;
    assign o_cfg_ready = 1'b1;

    // draw bounds and store addresses
    assign draw_ok   = !s_x[15] && !s_y[15] && (s_x < 16'(WIDTH)) && (s_y < 16'(ROWS));
    assign draw_addr = {s_y[3 +: PW], s_x[CW-1:0]};
    assign col_slot  = r_scan_slot - SW'(HEADER_SLOTS);
    assign scan_addr = {r_scan_page, col_slot[CW-1:0]};
    assign slot_wrap = (r_scan_slot == SW'(SLOTS - 1));
    assign page_wrap = (r_scan_page == PW'(PAGES - 1));

    // modified byte for the write-back
    always_comb begin
        case (r_mode)
            MODE_OFF:    mod_byte = ram_rdata & ~r_mask;
            MODE_INVERT: mod_byte = ram_rdata ^ r_mask;
            default:     mod_byte = ram_rdata | r_mask;
        endcase
    end

    // store port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = 8'd0;
        ram_addr  = (i_s_tuser == OP_DRAW) ? draw_addr : scan_addr;
        case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr_addr;
            end
            S_RMW: begin
                ram_we    = 1'b1;
                ram_addr  = r_addr;
                ram_wdata = mod_byte;
            end
            default: begin
            end
        endcase
    end

    pfr_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == {AW{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_accept) begin
                    case (i_s_tuser)
                        OP_DRAW:    n_state = draw_ok ? S_RMW : S_IDLE;
                        OP_CLEAR:   n_state = S_CLEAR;
                        OP_REFRESH: n_state = S_REFRESH;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RMW:     n_state = S_IDLE;
            S_REFRESH: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_scan_page <= '0;
            r_scan_slot <= '0;
            r_out_valid <= 1'b0;
            r_col_code  <= 8'd0;
            r_page_code <= 8'd0;
        end else begin
            r_state <= n_state;
            // sweep counter, restarted by a clear item
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end else begin
                r_clr_addr <= '0;
            end
            // refresh position
            if (s_accept && (i_s_tuser == OP_REFRESH)) begin
                if (slot_wrap) begin
                    r_scan_slot <= '0;
                    r_scan_page <= page_wrap ? '0 : r_scan_page + PW'(1);
                end else begin
                    r_scan_slot <= r_scan_slot + SW'(1);
                end
            end
            // output register
            if (m_accept) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_REFRESH) begin
                r_out_valid <= 1'b1;
            end
            // configuration
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_COL_CMD) r_col_code <= i_cfg_data;
                if (i_cfg_index == REG_PAGE_CMD) r_page_code <= i_cfg_data;
            end
        end
    end

    // item details carried to the write-back or refresh state
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_addr      <= draw_addr;
            r_mask      <= 8'd1 << s_y[2:0];
            r_mode      <= s_mode;
            r_is_data   <= (r_scan_slot >= SW'(HEADER_SLOTS));
            r_hdr_sel   <= r_scan_slot[1:0];
            r_hdr_page  <= r_scan_page;
            r_last_pend <= slot_wrap && page_wrap;
        end
    end

    // byte of the refresh word
    always_comb begin
        if (r_is_data) begin
            word_byte = ram_rdata;
        end else begin
            case (r_hdr_sel)
                SLOT_COL_CMD:  word_byte = r_col_code;
                SLOT_COL_ZERO: word_byte = 8'd0;
                SLOT_PAGE_CMD: word_byte = r_page_code;
                SLOT_PAGE_NUM: word_byte = 8'(r_hdr_page);
                default:       word_byte = 8'd0;
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_REFRESH) begin
            r_out_word <= spread_byte(word_byte, !r_is_data);
            r_out_last <= r_last_pend;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_word;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire
